FILE: hw/rtl/cpc_pkg.sv
`default_nettype none
// cpc_pkg: shared constants, vertex type and coordinate helpers for the
// convex polygon clipper. Used by cpc_div and convex_polygon_clipper.

package cpc_pkg;

  // default polygon capacities
  localparam int MAX_IN_VERTICES  = 8;
  localparam int MAX_OUT_VERTICES = 16;

  // datapath widths
  localparam int CRD_W  = 32;  // Q16.16 coordinate
  localparam int DIFF_W = 33;  // coordinate difference
  localparam int PROD_W = 66;  // product of two differences
  localparam int SIDE_W = 68;  // cross product (side test)
  localparam int DEN_W  = 69;  // sum of two side magnitudes
  localparam int AREA_W = 72;  // signed area accumulator

  // vertex packed as {y, x}
  typedef logic [2*CRD_W-1:0] vtx_t;

  function automatic logic [CRD_W-1:0] vx(input vtx_t v);
    vx = v[CRD_W-1:0];
  endfunction

  function automatic logic [CRD_W-1:0] vy(input vtx_t v);
    vy = v[2*CRD_W-1:CRD_W];
  endfunction

  // sign extend a coordinate to difference width
  function automatic logic signed [DIFF_W-1:0] sx(input logic [CRD_W-1:0] c);
    sx = DIFF_W'(signed'(c));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cpc_div.sv
`default_nettype none
// cpc_div: bit-serial scaled divider, q = round(pm * dmag / den), ties up.
// One bit of dmag per cycle, then a rounding step. Uses cpc_pkg widths.

module cpc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cpc_pkg::SIDE_W-1:0]  pm,
  input  wire logic [cpc_pkg::DEN_W-1:0]   den,
  input  wire logic [cpc_pkg::CRD_W-1:0]   dmag,
  output logic                             done,
  output logic [cpc_pkg::CRD_W:0]          q
);

  localparam int RW = cpc_pkg::DEN_W + 2;
  localparam int NB = cpc_pkg::CRD_W;
  localparam int KW = $clog2(NB);

  logic                        busy;
  logic                        fin;
  logic [KW-1:0]               cnt;
  logic [RW-1:0]               rem;
  logic [NB:0]                 qa;
  logic [NB-1:0]               dsh;
  logic [cpc_pkg::SIDE_W-1:0]  pm_r;
  logic [cpc_pkg::DEN_W-1:0]   den_r;

  logic [RW-1:0] r2;
  logic [RW-1:0] one_s;
  logic [RW-1:0] two_s;
  logic [RW-1:0] rem_next;
  logic [1:0]    k;
  logic          rnd;

  // one restoring step: remainder stays below den, quotient digit 0..2
  always_comb begin
    one_s = RW'(den_r);
    two_s = RW'({den_r, 1'b0});
    r2    = {rem[RW-2:0], 1'b0} + (dsh[NB-1] ? RW'(pm_r) : '0);
    if (r2 >= two_s) begin
      rem_next = r2 - two_s;
      k        = 2'd2;
    end else if (r2 >= one_s) begin
      rem_next = r2 - one_s;
      k        = 2'd1;
    end else begin
      rem_next = r2;
      k        = 2'd0;
    end
    rnd = ({rem[RW-2:0], 1'b0} >= one_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin && !start && !busy;
      if (start) begin
        busy  <= 1'b1;
        fin   <= 1'b0;
        cnt   <= '0;
        rem   <= '0;
        qa    <= '0;
        dsh   <= dmag;
        pm_r  <= pm;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_next;
        qa  <= {qa[NB-1:0], 1'b0} + (NB+1)'(k);
        dsh <= {dsh[NB-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == KW'(NB-1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        q    <= qa + (NB+1)'(rnd);
        fin  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/convex_polygon_clipper.sv
`default_nettype none
// convex_polygon_clipper: top level, sequencer around one shared multiplier
// and the cpc_div divider. Depends on cpc_pkg and cpc_div.

// Intersects two convex polygons by Sutherland-Hodgman clipping. Send subject
// vertices (tuser = 0), then clip vertices (tuser = 1), one per transaction;
// tlast marks the final vertex of each polygon and, on a clip vertex, starts
// the work. Loading accepts one vertex per cycle. The clip last then holds
// s_tready low for the whole run: the signed area of each polygon (one
// shared 33x33 multiplier, two products per edge), a copy of the subject
// vertices, then per clip edge a side test of each working vertex on that
// multiplier, a write per kept vertex, and two 32-step serial divisions per
// edge crossing. Results leave from the working memory, each read in
// ST_OU_RD before ST_OU_LD offers it. Vertices beyond MAX_OUT_VERTICES are
// dropped and flagged in every result item; an empty intersection gives one
// zero item flagged empty.

module convex_polygon_clipper #(
  parameter int MAX_IN_VERTICES  = cpc_pkg::MAX_IN_VERTICES,
  parameter int MAX_OUT_VERTICES = cpc_pkg::MAX_OUT_VERTICES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // vertex_x [31:0], vertex_y [63:32]
  input  wire logic [0:0]  s_tuser,   // mode [0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // out_x [31:0], out_y [63:32]
  output logic [1:0]       m_tuser,   // empty_res [0], overflow [1]
  output logic             m_tlast
);

  localparam int MI     = MAX_IN_VERTICES;
  localparam int MO     = MAX_OUT_VERTICES;
  localparam int NMAX   = (MI > MO) ? MI : MO;
  localparam int CW     = $clog2(MI + 1);
  localparam int PA     = $clog2(MI);
  localparam int NW     = $clog2(MO + 1);
  localparam int WA     = $clog2(2 * MO);
  localparam int LW     = $clog2(NMAX + 1);
  localparam int CRD_W  = cpc_pkg::CRD_W;
  localparam int DIFF_W = cpc_pkg::DIFF_W;
  localparam int PROD_W = cpc_pkg::PROD_W;
  localparam int SIDE_W = cpc_pkg::SIDE_W;
  localparam int DEN_W  = cpc_pkg::DEN_W;
  localparam int AREA_W = cpc_pkg::AREA_W;

  typedef enum logic [5:0] {
    ST_IDLE, ST_START,
    ST_AR_INIT, ST_AR_LDP, ST_AR_RD, ST_AR_M1, ST_AR_M2, ST_AR_M3, ST_AR_END,
    ST_CP_INIT, ST_CP_RD, ST_CP_WR,
    ST_ED_INIT, ST_ED_A, ST_ED_B, ST_ED_PV,
    ST_SD1, ST_SD2, ST_SD3,
    ST_LP_RD, ST_LP_LD, ST_LP_CHK,
    ST_DVX_GO, ST_DVX_W, ST_DVY_GO, ST_DVY_W,
    ST_PU_X, ST_PU_CUR, ST_LP_NEXT,
    ST_EMIT, ST_OU_EMPTY, ST_OU_RD, ST_OU_LD
  } state_t;

  state_t state;

  // loading state
  logic [CW-1:0] scnt;
  logic [CW-1:0] ccnt;
  logic          sdone;

  // sequencer registers
  logic [LW-1:0] idx;
  logic [NW-1:0] n;
  logic [NW-1:0] m;
  logic [CW-1:0] kcnt;
  logic          bank;
  logic          ovf;
  logic          psel;
  logic          rev_s;
  logic          rev_c;
  logic          is_prev;

  // datapath registers
  logic signed [AREA_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIFF_W-1:0] ex;
  logic signed [DIFF_W-1:0] ey;
  logic signed [SIDE_W-1:0] ps;
  logic signed [SIDE_W-1:0] cs;
  cpc_pkg::vtx_t            pv;
  cpc_pkg::vtx_t            qv;
  cpc_pkg::vtx_t            av;
  cpc_pkg::vtx_t            pvtx;
  cpc_pkg::vtx_t            cvtx;
  logic [CRD_W-1:0]         xx;
  logic [CRD_W-1:0]         yy;

  // memories
  cpc_pkg::vtx_t subj_mem [0:MI-1];
  cpc_pkg::vtx_t clip_mem [0:MI-1];
  cpc_pkg::vtx_t work_mem [0:2*MO-1];
  cpc_pkg::vtx_t subj_q;
  cpc_pkg::vtx_t clip_q;
  cpc_pkg::vtx_t work_q;
  cpc_pkg::vtx_t prd;

  logic [PA-1:0] paddr;
  logic [WA-1:0] waddr;
  logic [WA-1:0] wr_addr;
  cpc_pkg::vtx_t wr_data;
  logic          wr_en;
  logic          subj_we;
  logic          clip_we;
  logic          in_acc;

  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;

  logic [31:0] ar_n;
  logic [31:0] nxt_i;
  logic [31:0] bidx;
  logic [31:0] pa_t;
  logic [31:0] wa_t;
  logic [31:0] wr_t;
  logic [NW-1:0] ncp;

  logic signed [SIDE_W-1:0] side_v;
  logic [SIDE_W-1:0]        pmag;
  logic [SIDE_W-1:0]        cmag;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [CRD_W-1:0]         dmag;
  logic                     cin;
  logic                     pin;
  logic                     free_out;
  logic                     out_load;

  logic                dv_start;
  logic                dv_done;
  logic [DEN_W-1:0]    dv_den;
  logic [CRD_W:0]      dv_q;
  logic [DIFF_W-1:0]   x_res;
  logic [DIFF_W-1:0]   y_res;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign subj_we  = in_acc && !s_tuser[0] && !sdone && (32'(scnt) < 32'(MI));
  assign clip_we  = in_acc && s_tuser[0] && (32'(ccnt) < 32'(MI));
  assign free_out = !m_tvalid || m_tready;
  assign out_load = ((state == ST_OU_EMPTY) || (state == ST_OU_LD)) && free_out;
  assign prd      = psel ? clip_q : subj_q;

  // index helpers
  always_comb begin
    ar_n  = psel ? 32'(ccnt) : 32'(scnt);
    nxt_i = (32'(idx) + 32'd1 == ar_n) ? 32'd0 : 32'(idx) + 32'd1;
    bidx  = (32'(kcnt) + 32'd1 == 32'(ccnt)) ? 32'd0 : 32'(kcnt) + 32'd1;
    ncp   = (32'(scnt) > 32'(MO)) ? NW'(MO) : NW'(scnt);
  end

  // subject / clip read address
  always_comb begin
    pa_t = 32'd0;
    unique case (state)
      ST_AR_RD: pa_t = nxt_i;
      ST_CP_RD: pa_t = rev_s ? 32'(scnt) - 32'd1 - 32'(idx) : 32'(idx);
      ST_ED_INIT: pa_t = rev_c ? 32'(ccnt) - 32'd1 - 32'(kcnt) : 32'(kcnt);
      ST_ED_A: pa_t = rev_c ? 32'(ccnt) - 32'd1 - bidx : bidx;
      default: pa_t = 32'd0;
    endcase
    paddr = pa_t[PA-1:0];
  end

  // working memory read and write ports
  always_comb begin
    if (state == ST_ED_B) begin
      wa_t = (bank ? 32'(MO) : 32'd0) + 32'(n) - 32'd1;
    end else begin
      wa_t = (bank ? 32'(MO) : 32'd0) + 32'(idx);
    end
    waddr = wa_t[WA-1:0];
    if (state == ST_CP_WR) begin
      wr_t    = 32'(idx);
      wr_data = subj_q;
      wr_en   = 1'b1;
    end else begin
      wr_t    = (bank ? 32'd0 : 32'(MO)) + 32'(m);
      wr_data = (state == ST_PU_X) ? {yy, xx} : cvtx;
      wr_en   = ((state == ST_PU_X) || (state == ST_PU_CUR)) && (32'(m) < 32'(MO));
    end
    wr_addr = wr_t[WA-1:0];
  end

  always_ff @(posedge clk) begin
    if (subj_we) begin
      subj_mem[scnt[PA-1:0]] <= s_tdata;
    end
    if (clip_we) begin
      clip_mem[ccnt[PA-1:0]] <= s_tdata;
    end
    subj_q <= subj_mem[paddr];
    clip_q <= clip_mem[paddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      work_mem[wr_addr] <= wr_data;
    end
    work_q <= work_mem[waddr];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_AR_M1: begin
        mul_a = cpc_pkg::sx(cpc_pkg::vx(pv));
        mul_b = cpc_pkg::sx(cpc_pkg::vy(prd));
      end
      ST_AR_M2: begin
        mul_a = cpc_pkg::sx(cpc_pkg::vx(qv));
        mul_b = cpc_pkg::sx(cpc_pkg::vy(pv));
      end
      ST_SD1: begin
        mul_a = ex;
        mul_b = cpc_pkg::sx(cpc_pkg::vy(cvtx)) - cpc_pkg::sx(cpc_pkg::vy(av));
      end
      ST_SD2: begin
        mul_a = ey;
        mul_b = cpc_pkg::sx(cpc_pkg::vx(cvtx)) - cpc_pkg::sx(cpc_pkg::vx(av));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // side test and crossing operands
  always_comb begin
    side_v   = SIDE_W'(acc - AREA_W'(prod));
    pmag     = ps[SIDE_W-1] ? SIDE_W'(-ps) : SIDE_W'(ps);
    cmag     = cs[SIDE_W-1] ? SIDE_W'(-cs) : SIDE_W'(cs);
    dv_den   = DEN_W'(pmag) + DEN_W'(cmag);
    cin      = !cs[SIDE_W-1];
    pin      = !ps[SIDE_W-1];
    dx       = cpc_pkg::sx(cpc_pkg::vx(cvtx)) - cpc_pkg::sx(cpc_pkg::vx(pvtx));
    dy       = cpc_pkg::sx(cpc_pkg::vy(cvtx)) - cpc_pkg::sx(cpc_pkg::vy(pvtx));
    if (state == ST_DVY_GO) begin
      dmag = dy[DIFF_W-1] ? CRD_W'(-dy) : CRD_W'(dy);
    end else begin
      dmag = dx[DIFF_W-1] ? CRD_W'(-dx) : CRD_W'(dx);
    end
    dv_start = (state == ST_DVX_GO) || (state == ST_DVY_GO);
    x_res    = dx[DIFF_W-1] ? cpc_pkg::sx(cpc_pkg::vx(pvtx)) - dv_q
                            : cpc_pkg::sx(cpc_pkg::vx(pvtx)) + dv_q;
    y_res    = dy[DIFF_W-1] ? cpc_pkg::sx(cpc_pkg::vy(pvtx)) - dv_q
                            : cpc_pkg::sx(cpc_pkg::vy(pvtx)) + dv_q;
  end

  cpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .pm    (pmag),
    .den   (dv_den),
    .dmag  (dmag),
    .done  (dv_done),
    .q     (dv_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scnt     <= '0;
      ccnt     <= '0;
      sdone    <= 1'b0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (!s_tuser[0]) begin
              if (!sdone) begin
                if (subj_we) begin
                  scnt <= scnt + 1'b1;
                end
                if (s_tlast) begin
                  sdone <= 1'b1;
                end
              end
            end else begin
              if (clip_we) begin
                ccnt <= ccnt + 1'b1;
              end
              if (s_tlast) begin
                state <= ST_START;
              end
            end
          end
        end
        ST_START: begin
          ovf <= 1'b0;
          if (scnt != '0) begin
            psel  <= 1'b0;
            state <= ST_AR_INIT;
          end else begin
            rev_s <= 1'b0;
            psel  <= 1'b1;
            if (ccnt != '0) begin
              state <= ST_AR_INIT;
            end else begin
              rev_c <= 1'b0;
              state <= ST_CP_INIT;
            end
          end
        end
        // signed area of the selected polygon
        ST_AR_INIT: begin
          acc   <= '0;
          idx   <= '0;
          state <= ST_AR_LDP;
        end
        ST_AR_LDP: begin
          pv    <= prd;
          state <= ST_AR_RD;
        end
        ST_AR_RD: begin
          state <= ST_AR_M1;
        end
        ST_AR_M1: begin
          qv    <= prd;
          state <= ST_AR_M2;
        end
        ST_AR_M2: begin
          acc   <= acc + AREA_W'(prod);
          state <= ST_AR_M3;
        end
        ST_AR_M3: begin
          acc <= acc - AREA_W'(prod);
          pv  <= qv;
          if (32'(idx) + 32'd1 == ar_n) begin
            state <= ST_AR_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_AR_RD;
          end
        end
        ST_AR_END: begin
          if (!psel) begin
            rev_s <= acc[AREA_W-1];
            psel  <= 1'b1;
            if (ccnt != '0) begin
              state <= ST_AR_INIT;
            end else begin
              rev_c <= 1'b0;
              state <= ST_CP_INIT;
            end
          end else begin
            rev_c <= acc[AREA_W-1];
            state <= ST_CP_INIT;
          end
        end
        // subject into bank 0, truncated to capacity
        ST_CP_INIT: begin
          idx  <= '0;
          bank <= 1'b0;
          kcnt <= '0;
          n    <= ncp;
          if (32'(scnt) > 32'(MO)) begin
            ovf <= 1'b1;
          end
          state <= (ncp == '0) ? ST_EMIT : ST_CP_RD;
        end
        ST_CP_RD: begin
          state <= ST_CP_WR;
        end
        ST_CP_WR: begin
          if (32'(idx) + 32'd1 == 32'(n)) begin
            state <= ST_ED_INIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_CP_RD;
          end
        end
        // one pass per clip edge
        ST_ED_INIT: begin
          if ((kcnt == ccnt) || (n == '0)) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_ED_A;
          end
        end
        ST_ED_A: begin
          av    <= clip_q;
          state <= ST_ED_B;
        end
        ST_ED_B: begin
          ex    <= cpc_pkg::sx(cpc_pkg::vx(clip_q)) - cpc_pkg::sx(cpc_pkg::vx(av));
          ey    <= cpc_pkg::sx(cpc_pkg::vy(clip_q)) - cpc_pkg::sx(cpc_pkg::vy(av));
          state <= ST_ED_PV;
        end
        ST_ED_PV: begin
          cvtx    <= work_q;
          is_prev <= 1'b1;
          idx     <= '0;
          m       <= '0;
          state   <= ST_SD1;
        end
        // side test of cvtx against the edge
        ST_SD1: begin
          state <= ST_SD2;
        end
        ST_SD2: begin
          acc   <= AREA_W'(prod);
          state <= ST_SD3;
        end
        ST_SD3: begin
          if (is_prev) begin
            ps      <= side_v;
            pvtx    <= cvtx;
            is_prev <= 1'b0;
            state   <= ST_LP_RD;
          end else begin
            cs    <= side_v;
            state <= ST_LP_CHK;
          end
        end
        ST_LP_RD: begin
          state <= ST_LP_LD;
        end
        ST_LP_LD: begin
          cvtx  <= work_q;
          state <= ST_SD1;
        end
        ST_LP_CHK: begin
          if (cin != pin) begin
            state <= ST_DVX_GO;
          end else if (cin) begin
            state <= ST_PU_CUR;
          end else begin
            state <= ST_LP_NEXT;
          end
        end
        // edge crossing, one coordinate per division
        ST_DVX_GO: begin
          state <= ST_DVX_W;
        end
        ST_DVX_W: begin
          if (dv_done) begin
            xx    <= x_res[CRD_W-1:0];
            state <= ST_DVY_GO;
          end
        end
        ST_DVY_GO: begin
          state <= ST_DVY_W;
        end
        ST_DVY_W: begin
          if (dv_done) begin
            yy    <= y_res[CRD_W-1:0];
            state <= ST_PU_X;
          end
        end
        ST_PU_X: begin
          if (32'(m) < 32'(MO)) begin
            m <= m + 1'b1;
          end else begin
            ovf <= 1'b1;
          end
          state <= cin ? ST_PU_CUR : ST_LP_NEXT;
        end
        ST_PU_CUR: begin
          if (32'(m) < 32'(MO)) begin
            m <= m + 1'b1;
          end else begin
            ovf <= 1'b1;
          end
          state <= ST_LP_NEXT;
        end
        ST_LP_NEXT: begin
          pvtx <= cvtx;
          ps   <= cs;
          if (32'(idx) + 32'd1 == 32'(n)) begin
            bank  <= !bank;
            n     <= m;
            kcnt  <= kcnt + 1'b1;
            state <= ST_ED_INIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_LP_RD;
          end
        end
        // result transactions
        ST_EMIT: begin
          scnt  <= '0;
          ccnt  <= '0;
          sdone <= 1'b0;
          idx   <= '0;
          state <= (n == '0) ? ST_OU_EMPTY : ST_OU_RD;
        end
        ST_OU_EMPTY: begin
          if (free_out) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= {ovf, 1'b1};
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_OU_RD: begin
          state <= ST_OU_LD;
        end
        ST_OU_LD: begin
          if (free_out) begin
            m_tvalid <= 1'b1;
            m_tdata  <= work_q;
            m_tuser  <= {ovf, 1'b0};
            m_tlast  <= (32'(idx) + 32'd1 == 32'(n));
            if (32'(idx) + 32'd1 == 32'(n)) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_OU_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // vertex counts never pass the buffer depths
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (32'(scnt) <= 32'(MI)) && (32'(ccnt) <= 32'(MI)) && (32'(n) <= 32'(MO)))
    else $error("vertex count beyond buffer depth");

  // the clip last starts the run and closes the input
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] && s_tlast) |=> !s_tready)
    else $error("input still open after clip last");

  // an empty result is a single zero transaction
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
    else $error("empty result not a single zero transaction");

  // a divider result only arrives while the sequencer waits for it
  a_div: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> ((state == ST_DVX_W) || (state == ST_DVY_W)))
    else $error("divider result outside a crossing");
`endif

endmodule

`default_nettype wire
